[rtl/rhj_pkg.sv]
// rhj_pkg: shared types and constants for the radix hash join engine.
// Used by rhj_front, rhj_back and radix_hash_join_engine; no dependencies.
`timescale 1ns / 1ps
package rhj_pkg;

  localparam int KEY_W = 32;
  localparam int PAY_W = 32;
  localparam int SHIFT_W = 5;
  localparam int DEF_BUILD_CAPACITY = 4096;
  localparam int DEF_MAX_BUCKETS = 1024;
  localparam int MAX_RUN = 64;
  localparam int RUN_W = $clog2(MAX_RUN + 2);
  localparam int MIN_BUCKET_BITS = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_LOAD_LAST,
    OP_PROBE
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } q_item_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_SIZE,
    ST_CLR,
    ST_H0,
    ST_H1,
    ST_H2,
    ST_P0,
    ST_P1,
    ST_PEND,
    ST_S0,
    ST_S1,
    ST_S2,
    ST_Q0,
    ST_Q1,
    ST_C0,
    ST_C1,
    ST_NOMATCH,
    ST_E0,
    ST_E1
  } state_t;

endpackage

[rtl/rhj_front.sv]
// rhj_front: accepts input beats, classifies them and queues them for the back end.
// Depends on rhj_pkg.
`timescale 1ns / 1ps
module rhj_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [63:0]           in_tdata,
  input  logic                  in_tuser,
  input  logic                  in_tlast,
  output logic                  q_valid,
  output rhj_pkg::q_item_t      q_item,
  input  logic                  q_pop
);
  import rhj_pkg::*;

  q_item_t             slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;
  q_item_t             item;
  logic                push, pop;

  always_comb begin
    item.key     = in_tdata[KEY_W-1:0];
    item.payload = in_tdata[KEY_W+PAY_W-1:KEY_W];
    if (in_tuser) begin
      item.op = OP_PROBE;
    end else if (in_tlast) begin
      item.op = OP_LOAD_LAST;
    end else begin
      item.op = OP_LOAD;
    end
  end

  assign in_tready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign q_valid   = (cnt_r != '0);
  assign q_item    = slot_r[rp_r];
  assign push      = in_tvalid && in_tready;
  assign pop       = q_pop && q_valid;

  always_comb begin
    wp_nxt  = push ? QPTR_W'(wp_r + 1'b1) : wp_r;
    rp_nxt  = pop ? QPTR_W'(rp_r + 1'b1) : rp_r;
    cnt_nxt = QCNT_W'(cnt_r + QCNT_W'(push) - QCNT_W'(pop));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= item;
    end
  end

endmodule

[rtl/rhj_back.sv]
// rhj_back: tuple stores, build pass (histogram, prefix sum, scatter) and bucket probe.
// Depends on rhj_pkg; fed by rhj_front.
`timescale 1ns / 1ps
module rhj_back #(
  parameter int BUILD_CAPACITY = rhj_pkg::DEF_BUILD_CAPACITY,
  parameter int MAX_BUCKETS    = rhj_pkg::DEF_MAX_BUCKETS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [rhj_pkg::SHIFT_W-1:0]   cfg_wr_data,
  input  logic                          q_valid,
  input  rhj_pkg::q_item_t              q_item,
  output logic                          q_pop,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [63:0]                   out_tdata,
  output logic [1:0]                    out_tuser,
  output logic                          out_tlast
);
  import rhj_pkg::*;

  localparam int CNT_W = $clog2(BUILD_CAPACITY + 1);
  localparam int IDX_W = $clog2(BUILD_CAPACITY);
  localparam int BKT_W = $clog2(MAX_BUCKETS);
  localparam int SI_W  = $clog2(MAX_BUCKETS + 1);
  localparam int BB_W  = $clog2(BKT_W + 1);

  logic [KEY_W-1:0] lkeys [BUILD_CAPACITY];
  logic [PAY_W-1:0] lpays [BUILD_CAPACITY];
  logic [KEY_W-1:0] bkeys [BUILD_CAPACITY];
  logic [PAY_W-1:0] bpays [BUILD_CAPACITY];
  logic [CNT_W-1:0] cnts  [MAX_BUCKETS];
  logic [CNT_W-1:0] starts [MAX_BUCKETS + 1];

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt, i_r, i_nxt, acc_r, acc_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt, hi_r, hi_nxt, j_r, j_nxt;
  logic [BKT_W-1:0]   idx_r, idx_nxt, h_r, h_nxt;
  logic [BB_W-1:0]    bits_r, bits_nxt;
  logic [SHIFT_W-1:0] shift_r;
  logic               sealed_r, sealed_nxt, built_r, built_nxt;
  logic [KEY_W-1:0]   key_r, key_nxt;
  logic [PAY_W-1:0]   pay_r, pay_nxt;
  logic [RUN_W-1:0]   total_r, total_nxt, n_r, n_nxt, limit;
  logic               out_valid_r, out_valid_nxt;
  logic [PAY_W-1:0]   out_pp_r, out_pp_nxt, out_bp_r, out_bp_nxt;
  logic               out_m_r, out_m_nxt, out_t_r, out_t_nxt, out_l_r, out_l_nxt;

  logic [KEY_W-1:0]   lkey_rd, bkey_rd;
  logic [PAY_W-1:0]   lpay_rd, bpay_rd;
  logic [CNT_W-1:0]   cnt_rd, st_lo_rd, st_hi_rd;

  logic               lk_we, bk_we, cn_we, st_we;
  logic [IDX_W-1:0]   lk_addr, bk_addr;
  logic [KEY_W-1:0]   lk_wkey, bk_wkey;
  logic [PAY_W-1:0]   lk_wpay, bk_wpay;
  logic [BKT_W-1:0]   cn_waddr, cn_raddr;
  logic [CNT_W-1:0]   cn_wdata, st_wdata;
  logic [SI_W-1:0]    st_waddr;
  logic [BKT_W-1:0]   mask;
  logic               out_free;

  function automatic logic [BKT_W-1:0] bucket_of(input logic [KEY_W-1:0] k,
                                                 input logic [SHIFT_W-1:0] sh,
                                                 input logic [BKT_W-1:0] m);
    logic [KEY_W-1:0] s;
    s = k >> sh;
    return s[BKT_W-1:0] & m;
  endfunction

  always_comb begin
    for (int k = 0; k < BKT_W; k++) begin
      mask[k] = (k < int'(bits_r));
    end
  end

  assign out_free = !out_valid_r || out_tready;
  assign limit    = (total_r > RUN_W'(MAX_RUN)) ? RUN_W'(MAX_RUN) : total_r;

  always_comb begin
    logic [CNT_W-1:0] eff;
    logic [CNT_W-1:0] m1;
    int               cl;
    int               b;
    state_nxt     = state_r;
    count_nxt     = count_r;
    i_nxt         = i_r;
    acc_nxt       = acc_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    j_nxt         = j_r;
    idx_nxt       = idx_r;
    h_nxt         = h_r;
    bits_nxt      = bits_r;
    sealed_nxt    = sealed_r;
    built_nxt     = built_r;
    key_nxt       = key_r;
    pay_nxt       = pay_r;
    total_nxt     = total_r;
    n_nxt         = n_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_pp_nxt    = out_pp_r;
    out_bp_nxt    = out_bp_r;
    out_m_nxt     = out_m_r;
    out_t_nxt     = out_t_r;
    out_l_nxt     = out_l_r;
    q_pop         = 1'b0;
    lk_we         = 1'b0;
    bk_we         = 1'b0;
    cn_we         = 1'b0;
    st_we         = 1'b0;
    eff           = sealed_r ? '0 : count_r;
    lk_addr       = eff[IDX_W-1:0];
    lk_wkey       = q_item.key;
    lk_wpay       = q_item.payload;
    bk_addr       = cnt_rd[IDX_W-1:0];
    bk_wkey       = lkey_rd;
    bk_wpay       = lpay_rd;
    cn_waddr      = idx_r;
    cn_wdata      = '0;
    cn_raddr      = idx_r;
    st_waddr      = SI_W'(idx_r);
    st_wdata      = acc_r;
    m1            = CNT_W'(count_r - 1'b1);
    cl            = 0;
    b             = 0;
    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          if (q_item.op == OP_PROBE) begin
            key_nxt   = q_item.key;
            pay_nxt   = q_item.payload;
            h_nxt     = bucket_of(q_item.key, shift_r, mask);
            state_nxt = ST_Q0;
          end else begin
            sealed_nxt = 1'b0;
            if (eff < CNT_W'(BUILD_CAPACITY)) begin
              lk_we     = 1'b1;
              count_nxt = CNT_W'(eff + 1'b1);
            end else begin
              count_nxt = eff;
            end
            if (q_item.op == OP_LOAD_LAST) begin
              state_nxt = ST_SIZE;
            end
          end
        end
      end
      ST_SIZE: begin
        for (int k = 0; k < CNT_W; k++) begin
          if (m1[k]) cl = k + 1;
        end
        if (count_r == '0) cl = 0;
        b = cl - 2;
        if (b < MIN_BUCKET_BITS) b = MIN_BUCKET_BITS;
        if (b > BKT_W) b = BKT_W;
        bits_nxt  = BB_W'(b);
        idx_nxt   = '0;
        state_nxt = ST_CLR;
      end
      ST_CLR: begin
        cn_we = 1'b1;
        if (idx_r == mask) begin
          i_nxt     = '0;
          state_nxt = ST_H0;
        end else begin
          idx_nxt = BKT_W'(idx_r + 1'b1);
        end
      end
      ST_H0: begin
        if (i_r == count_r) begin
          idx_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = ST_P0;
        end else begin
          state_nxt = ST_H1;
        end
      end
      ST_H1: begin
        cn_raddr  = bucket_of(lkey_rd, shift_r, mask);
        h_nxt     = cn_raddr;
        state_nxt = ST_H2;
      end
      ST_H2: begin
        cn_we     = 1'b1;
        cn_waddr  = h_r;
        cn_wdata  = CNT_W'(cnt_rd + 1'b1);
        i_nxt     = CNT_W'(i_r + 1'b1);
        state_nxt = ST_H0;
      end
      ST_P0: begin
        state_nxt = ST_P1;
      end
      ST_P1: begin
        cn_we    = 1'b1;
        cn_wdata = acc_r;
        st_we    = 1'b1;
        acc_nxt  = CNT_W'(acc_r + cnt_rd);
        if (idx_r == mask) begin
          state_nxt = ST_PEND;
        end else begin
          idx_nxt   = BKT_W'(idx_r + 1'b1);
          state_nxt = ST_P0;
        end
      end
      ST_PEND: begin
        st_we     = 1'b1;
        st_waddr  = SI_W'(SI_W'(mask) + 1'b1);
        st_wdata  = count_r;
        i_nxt     = '0;
        state_nxt = ST_S0;
      end
      ST_S0: begin
        if (i_r == count_r) begin
          sealed_nxt = 1'b1;
          built_nxt  = 1'b1;
          state_nxt  = ST_IDLE;
        end else begin
          state_nxt = ST_S1;
        end
      end
      ST_S1: begin
        cn_raddr  = bucket_of(lkey_rd, shift_r, mask);
        h_nxt     = cn_raddr;
        state_nxt = ST_S2;
      end
      ST_S2: begin
        bk_we     = 1'b1;
        cn_we     = 1'b1;
        cn_waddr  = h_r;
        cn_wdata  = CNT_W'(cnt_rd + 1'b1);
        i_nxt     = CNT_W'(i_r + 1'b1);
        state_nxt = ST_S0;
      end
      ST_Q0: begin
        state_nxt = ST_Q1;
      end
      ST_Q1: begin
        lo_nxt    = built_r ? st_lo_rd : '0;
        hi_nxt    = built_r ? st_hi_rd : '0;
        j_nxt     = built_r ? st_lo_rd : '0;
        total_nxt = '0;
        state_nxt = ST_C0;
      end
      ST_C0: begin
        if (j_r == hi_r) begin
          if (total_r == '0) begin
            state_nxt = ST_NOMATCH;
          end else begin
            j_nxt     = lo_r;
            n_nxt     = '0;
            state_nxt = ST_E0;
          end
        end else begin
          state_nxt = ST_C1;
        end
      end
      ST_C1: begin
        if (bkey_rd == key_r && total_r <= RUN_W'(MAX_RUN)) begin
          total_nxt = RUN_W'(total_r + 1'b1);
        end
        j_nxt     = CNT_W'(j_r + 1'b1);
        state_nxt = ST_C0;
      end
      ST_NOMATCH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pp_nxt    = pay_r;
          out_bp_nxt    = '0;
          out_m_nxt     = 1'b0;
          out_t_nxt     = 1'b0;
          out_l_nxt     = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      ST_E0: begin
        state_nxt = (j_r == hi_r) ? ST_IDLE : ST_E1;
      end
      ST_E1: begin
        if (bkey_rd == key_r) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_pp_nxt    = pay_r;
            out_bp_nxt    = bpay_rd;
            out_m_nxt     = 1'b1;
            out_t_nxt     = (total_r > RUN_W'(MAX_RUN));
            out_l_nxt     = (RUN_W'(n_r + 1'b1) == limit);
            n_nxt         = RUN_W'(n_r + 1'b1);
            j_nxt         = CNT_W'(j_r + 1'b1);
            state_nxt     = (RUN_W'(n_r + 1'b1) == limit) ? ST_IDLE : ST_E0;
          end
        end else begin
          j_nxt     = CNT_W'(j_r + 1'b1);
          state_nxt = ST_E0;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      sealed_r    <= 1'b0;
      built_r     <= 1'b0;
      bits_r      <= BB_W'(MIN_BUCKET_BITS);
      shift_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      sealed_r    <= sealed_nxt;
      built_r     <= built_nxt;
      bits_r      <= bits_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        shift_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    acc_r    <= acc_nxt;
    lo_r     <= lo_nxt;
    hi_r     <= hi_nxt;
    j_r      <= j_nxt;
    idx_r    <= idx_nxt;
    h_r      <= h_nxt;
    key_r    <= key_nxt;
    pay_r    <= pay_nxt;
    total_r  <= total_nxt;
    n_r      <= n_nxt;
    out_pp_r <= out_pp_nxt;
    out_bp_r <= out_bp_nxt;
    out_m_r  <= out_m_nxt;
    out_t_r  <= out_t_nxt;
    out_l_r  <= out_l_nxt;
  end

  always_ff @(posedge clk) begin
    if (lk_we) begin
      lkeys[lk_addr] <= lk_wkey;
      lpays[lk_addr] <= lk_wpay;
    end
    lkey_rd <= lkeys[i_r[IDX_W-1:0]];
    lpay_rd <= lpays[i_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (bk_we) begin
      bkeys[bk_addr] <= bk_wkey;
      bpays[bk_addr] <= bk_wpay;
    end
    bkey_rd <= bkeys[j_r[IDX_W-1:0]];
    bpay_rd <= bpays[j_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cn_we) begin
      cnts[cn_waddr] <= cn_wdata;
    end
    cnt_rd <= cnts[cn_raddr];
  end

  always_ff @(posedge clk) begin
    if (st_we) begin
      starts[st_waddr] <= st_wdata;
    end
    st_lo_rd <= starts[SI_W'(h_r)];
    st_hi_rd <= starts[SI_W'(SI_W'(h_r) + 1'b1)];
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_bp_r, out_pp_r};
  assign out_tuser  = {out_t_r, out_m_r};
  assign out_tlast  = out_l_r;

endmodule

[rtl/radix_hash_join_engine.sv]
// radix_hash_join_engine: top level of the equi-join engine, front queue plus back end.
// Depends on rhj_pkg, rhj_front and rhj_back.
//
// channel | dir | tdata (low bit up)                 | tuser             | tlast
// in_     | in  | tuple_key, tuple_payload           | cmd               | build_last
// out_    | out | probe_payload, build_payload       | matched,truncated | run_last
// cfg_    | in  | cfg_wr_data = radix_shift, written when cfg_wr_en is high
//
// A plain load is stored while the back end stays idle; the last load starts a build
// pass (clear, histogram, prefix sum, scatter), paced by the shared count memory port.
// A probe scans its bucket to count matches and, if there are any, scans it again to emit them;
// it waits whenever the output is stalled.
// Reset clears control state only; stores need no clearing pass.
// A two-beat queue lets input beats land while the back end works or the output stalls.
`timescale 1ns / 1ps
module radix_hash_join_engine #(
  parameter int BUILD_CAPACITY = rhj_pkg::DEF_BUILD_CAPACITY,
  parameter int MAX_BUCKETS    = rhj_pkg::DEF_MAX_BUCKETS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [rhj_pkg::SHIFT_W-1:0] cfg_wr_data,  // radix_shift
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [63:0]                 in_tdata,     // tuple_key, tuple_payload
  input  logic                        in_tuser,     // cmd
  input  logic                        in_tlast,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [63:0]                 out_tdata,    // probe_payload, build_payload
  output logic [1:0]                  out_tuser,    // matched, truncated
  output logic                        out_tlast
);
  import rhj_pkg::*;

  logic    q_valid, q_pop;
  q_item_t q_item;

  rhj_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop)
  );

  rhj_back #(
    .BUILD_CAPACITY (BUILD_CAPACITY),
    .MAX_BUCKETS    (MAX_BUCKETS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .out_tlast   (out_tlast)
  );

endmodule

[tb/tb.sv]
// tb: self-checking bench for radix_hash_join_engine, build/probe join traffic.
// Depends on rhj_pkg and the engine RTL; a clocked driver and monitor share an expected queue.
`timescale 1ns / 1ps
module tb;
  import rhj_pkg::*;

  localparam int CAP = 4096;
  localparam int NBKT = 1024;
  localparam int WDOG_LIMIT = 200000;
  localparam int DRAIN = 3 * NBKT + 6 * (CAP + 8) + 400;

  typedef struct {
    bit        cmd;
    bit [31:0] key;
    bit [31:0] pay;
    bit        last;
  } tuple_t;

  typedef struct {
    bit [31:0] probe_pay;
    bit [31:0] build_pay;
    bit        matched;
    bit        truncated;
    bit        run_last;
  } join_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [4:0]  cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  radix_hash_join_engine i_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // join table model
  bit [31:0] ld_key [CAP];
  bit [31:0] ld_pay [CAP];
  bit [31:0] bk_key [CAP];
  bit [31:0] bk_pay [CAP];
  int unsigned bk_start [NBKT+1];
  int unsigned bk_cnt [NBKT];
  int unsigned bk_fill [NBKT];
  int unsigned n_loaded = 0;
  int unsigned bkt_bits = 2;
  bit          sealed = 0;
  bit [4:0]    shift_q = '0;

  tuple_t    pending[$];
  join_row_t rows_exp[$];
  int        idle_in = 0;
  int        idle_out = 0;
  bit        stall_req = 0;
  int        stall_cnt = 0;
  int        errors = 0;
  int        wdog = 0;

  function automatic int unsigned bucket_of(bit [31:0] k);
    return (k >> shift_q) & ((32'd1 << bkt_bits) - 1);
  endfunction

  function automatic void seal_model();
    longint unsigned p;
    int unsigned nb, acc, h, d;
    p = 1;
    acc = 0;
    while (p < n_loaded) p = p << 1;
    p = p >> 2;
    if (p < 4) p = 4;
    if (p > NBKT) p = NBKT;
    bkt_bits = 0;
    while ((64'd1 << bkt_bits) < p) bkt_bits++;
    nb = 1 << bkt_bits;
    for (int i = 0; i < NBKT; i++) bk_cnt[i] = 0;
    for (int i = 0; i < n_loaded; i++) bk_cnt[bucket_of(ld_key[i])]++;
    for (int i = 0; i < nb; i++) begin
      bk_start[i] = acc;
      bk_fill[i] = acc;
      acc += bk_cnt[i];
    end
    bk_start[nb] = n_loaded;
    for (int i = 0; i < n_loaded; i++) begin
      h = bucket_of(ld_key[i]);
      d = bk_fill[h]++;
      if (d < CAP) begin
        bk_key[d] = ld_key[i];
        bk_pay[d] = ld_pay[i];
      end
    end
    sealed = 1;
  endfunction

  function automatic void join_step(tuple_t t);
    int unsigned h, lo, hi, total, n;
    join_row_t r;
    if (!t.cmd) begin
      if (sealed) begin
        n_loaded = 0;
        sealed = 0;
      end
      if (n_loaded < CAP) begin
        ld_key[n_loaded] = t.key;
        ld_pay[n_loaded] = t.pay;
        n_loaded++;
      end
      if (t.last) seal_model();
      return;
    end
    h = bucket_of(t.key);
    lo = bk_start[h];
    hi = bk_start[h+1];
    if (hi > CAP) hi = CAP;
    total = 0;
    n = 0;
    for (int j = lo; j < hi; j++) if (bk_key[j] == t.key) total++;
    if (total == 0) begin
      r = '{t.pay, 32'd0, 1'b0, 1'b0, 1'b1};
      rows_exp.push_back(r);
      return;
    end
    for (int j = lo; j < hi && n < MAX_RUN; j++) begin
      if (bk_key[j] == t.key) begin
        n++;
        r = '{t.pay, bk_pay[j], 1'b1, total > MAX_RUN, (n == MAX_RUN) || (n == total)};
        rows_exp.push_back(r);
      end
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (in_tvalid) join_step('{in_tuser, in_tdata[31:0], in_tdata[63:32], in_tlast});
      if (pending.size() > 0 && $urandom_range(99) >= idle_in) begin
        in_tvalid <= 1'b1;
        in_tuser <= pending[0].cmd;
        in_tdata <= {pending[0].pay, pending[0].key};
        in_tlast <= pending[0].last;
        void'(pending.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    join_row_t e;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (rows_exp.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected beat %h %b %b", out_tdata, out_tuser, out_tlast);
        end else begin
          e = rows_exp.pop_front();
          if (out_tdata !== {e.build_pay, e.probe_pay} ||
              out_tuser !== {e.truncated, e.matched} || out_tlast !== e.run_last) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp %h %b%b %b got %h %b %b",
                       {e.build_pay, e.probe_pay}, e.truncated, e.matched, e.run_last,
                       out_tdata, out_tuser, out_tlast);
          end
        end
      end
      if (stall_req && stall_cnt < 600) begin
        stall_cnt <= stall_cnt + 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= $urandom_range(99) >= idle_out;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("[radix_hash_join_engine] ERROR");
      $finish;
    end
  end

  function automatic void add(bit cmd, bit [31:0] key, bit [31:0] pay, bit last);
    pending.push_back('{cmd, key, pay, last});
  endfunction

  task automatic drain();
    wait (pending.size() == 0 && !in_tvalid);
    wait (rows_exp.size() == 0);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic set_shift(bit [4:0] v);
    drain();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    shift_q = v;
  endtask

  task automatic random_phase(int n_items);
    bit [31:0] pool [8];
    int cnt, nl, np;
    cnt = 0;
    while (cnt < n_items) begin
      foreach (pool[i]) pool[i] = $urandom;
      nl = ($urandom_range(9) == 0) ? $urandom_range(80, 140) : $urandom_range(1, 30);
      for (int i = 0; i < nl; i++)
        add(0, ($urandom_range(5) == 0) ? $urandom : pool[$urandom_range(7)], $urandom,
            (i == nl - 1) && ($urandom_range(7) != 0));
      np = $urandom_range(3, 12);
      for (int i = 0; i < np; i++)
        add(1, ($urandom_range(4) == 0) ? $urandom : pool[$urandom_range(7)], $urandom,
            $urandom_range(1));
      cnt += nl + np;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // probes before any build, ignored tlast on a probe
    add(1, 32'h0, 32'h0, 0);
    add(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    // heavy key forces truncation, plus extremes
    for (int i = 0; i < 70; i++) add(0, 32'hA5A5_0003, i, 0);
    add(0, 32'h0, 32'hFFFF_FFFF, 0);
    add(0, 32'hFFFF_FFFF, 32'h0, 0);
    add(0, 32'h0001_0000, 32'h1234_5678, 1);
    add(1, 32'hA5A5_0003, 32'hDEAD_BEEF, 0);
    add(1, 32'h0, 32'h1, 0);
    add(1, 32'hFFFF_FFFF, 32'h2, 0);
    add(1, 32'h0001_0000, 32'h3, 0);
    add(1, 32'h7777_7777, 32'h4, 0);
    // shift change with the old table still live
    set_shift(5'd16);
    add(1, 32'h0001_0000, 32'h5, 0);
    add(1, 32'hA5A5_0003, 32'h6, 0);
    add(1, 32'hFFFF_FFFF, 32'h7, 0);

    idle_in = 19; idle_out = 56;
    random_phase(60);
    set_shift($urandom_range(1, 15));
    idle_in = 56; idle_out = 19;
    random_phase(60);
    set_shift(5'd0);
    idle_in = 0; idle_out = 0;
    stall_req = 1;
    random_phase(60);

    drain();
    if (errors == 0 && rows_exp.size() == 0) begin
      $display("[radix_hash_join_engine] OK");
    end else begin
      $display("[radix_hash_join_engine] ERROR");
    end
    $finish;
  end
endmodule

[files.f]
rtl/rhj_pkg.sv
rtl/rhj_front.sv
rtl/rhj_back.sv
rtl/radix_hash_join_engine.sv
tb/tb.sv
